@@ hw/rtl/bilinear_sampler_wrap_clamp_defines.svh @@
// Assertion macros used by the checker in bsw_checker.sv.
`ifndef BILINEAR_SAMPLER_WRAP_CLAMP_DEFINES_SVH
`define BILINEAR_SAMPLER_WRAP_CLAMP_DEFINES_SVH

// Same-cycle implication.
`define BSW_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BSW_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/bsw_pkg.sv @@
package bsw_pkg;

    localparam int DEF_MAX_COLS     = 256;
    localparam int DEF_MAX_ROWS     = 256;
    localparam int DEF_CHANNEL_BITS = 16;

    localparam int FRAC_BITS = 16;
    localparam int COORD_W   = 20;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 2;
    localparam int PIX_W     = 8;
    localparam int IN_CH_W   = 16;
    localparam int OUT_CH_W  = 16;

    // u*w with w as a signed operand one bit wider
    localparam int PROD_W  = COORD_W + CFG_W + 1;
    localparam int FLR_W   = PROD_W - FRAC_BITS;
    localparam int MAG_W   = FLR_W;
    localparam int WT_W    = FRAC_BITS + 1;
    localparam int BLEND_W = 2 * FRAC_BITS + 1;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH  = 9'd256;
    localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT = 9'd256;

    localparam logic [WT_W-1:0]          ONE_FX  = 17'h10000;
    localparam logic signed [PROD_W-1:0] HALF_FX = PROD_W'(32768);

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROD,
        S_SPLIT,
        S_MOD,
        S_WRAP,
        S_FETCH,
        S_DRAIN,
        S_OUT
    } t_state;

    typedef struct packed {
        logic       accept;
        logic       sample;
        logic       split;
        logic       wrap;
        logic       fetch;
        logic [1:0] nbr;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic zero;
        logic mod_busy;
    } t_status;

endpackage

@@ hw/rtl/bilinear_sampler_wrap_clamp.sv @@
// Bilinear RGB sampler over an internal image store, column wrapped modulo the
// width and row clamped to the height. A write beat stores one pixel as it is
// accepted and gives no result. A sample beat runs through these steps in order
// once accepted: scale u and v, split them into integer and fraction, wrap the
// column in the serial remainder unit (one dividend bit per cycle over 14 bits,
// then hand back the remainder), form the wrapped column pair, do four serial
// reads of the single-port image store, drain the multiply and accumulate, and
// load the output register once it is free. The next beat is accepted the cycle
// after that load. Samples are handled one at a time; a finished result waits in
// the output register while the next beat is accepted, and a sample that
// finishes while the previous result is still stalled waits until it leaves.
// A width or height of zero returns black, skipping the store reads. The store
// has no reset; reading a pixel that was never written gives undefined color.
// Configuration writes are always ready and take effect at once.
module bilinear_sampler_wrap_clamp #(
    parameter int MAX_COLS     = bsw_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS     = bsw_pkg::DEF_MAX_ROWS,
    parameter int CHANNEL_BITS = bsw_pkg::DEF_CHANNEL_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic        [bsw_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic        [bsw_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic                                  i_command,
    input  logic        [bsw_pkg::PIX_W-1:0]      i_pixel_col,
    input  logic        [bsw_pkg::PIX_W-1:0]      i_pixel_row,
    input  logic        [bsw_pkg::IN_CH_W-1:0]    i_red_in,
    input  logic        [bsw_pkg::IN_CH_W-1:0]    i_green_in,
    input  logic        [bsw_pkg::IN_CH_W-1:0]    i_blue_in,
    input  logic signed [bsw_pkg::COORD_W-1:0]    i_u_coord,
    input  logic signed [bsw_pkg::COORD_W-1:0]    i_v_coord,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic        [bsw_pkg::OUT_CH_W-1:0]   o_red_out,
    output logic        [bsw_pkg::OUT_CH_W-1:0]   o_green_out,
    output logic        [bsw_pkg::OUT_CH_W-1:0]   o_blue_out
);

    bsw_pkg::t_cmd    cmd;
    bsw_pkg::t_status status;

    assign o_cfg_ready = 1'b1;

    bsw_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_command (i_command),
        .i_ready   (i_ready),
        .i_status  (status),
        .o_ready   (o_ready),
        .o_valid   (o_valid),
        .o_cmd     (cmd)
    );

    bsw_dp #(
        .MAX_COLS     (MAX_COLS),
        .MAX_ROWS     (MAX_ROWS),
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_command   (i_command),
        .i_pixel_col (i_pixel_col),
        .i_pixel_row (i_pixel_row),
        .i_red_in    (i_red_in),
        .i_green_in  (i_green_in),
        .i_blue_in   (i_blue_in),
        .i_u_coord   (i_u_coord),
        .i_v_coord   (i_v_coord),
        .o_red_out   (o_red_out),
        .o_green_out (o_green_out),
        .o_blue_out  (o_blue_out)
    );

endmodule

@@ hw/rtl/bsw_mod.sv @@
module bsw_mod (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [bsw_pkg::FLR_W-1:0]   i_dividend,
    input  logic        [bsw_pkg::CFG_W-1:0]   i_divisor,
    output logic                               o_busy,
    output logic        [bsw_pkg::CFG_W-1:0]   o_result
);

    localparam int CNT_W = $clog2(bsw_pkg::MAG_W + 1);

    logic                        r_busy;
    logic [CNT_W-1:0]            r_cnt;
    logic [bsw_pkg::MAG_W-1:0]   r_mag;
    logic [bsw_pkg::CFG_W-1:0]   r_rem;
    logic [bsw_pkg::CFG_W-1:0]   r_div;
    logic                        r_neg;

    logic [bsw_pkg::MAG_W-1:0]   mag;
    logic [bsw_pkg::CFG_W:0]     trial;
    logic [bsw_pkg::CFG_W:0]     trial_sub;
    logic [bsw_pkg::CFG_W-1:0]   n_rem;

    assign mag = i_dividend[bsw_pkg::FLR_W-1] ? bsw_pkg::MAG_W'(-i_dividend)
                                               : bsw_pkg::MAG_W'(i_dividend);

    // restoring remainder, one dividend bit per cycle
    assign trial     = {r_rem, r_mag[bsw_pkg::MAG_W-1]};
    assign trial_sub = trial - {1'b0, r_div};
    assign n_rem     = (trial >= {1'b0, r_div}) ? trial_sub[bsw_pkg::CFG_W-1:0]
                                                : trial[bsw_pkg::CFG_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(bsw_pkg::MAG_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mag <= mag;
            r_rem <= '0;
            r_div <= i_divisor;
            r_neg <= i_dividend[bsw_pkg::FLR_W-1];
        end else if (r_busy) begin
            r_mag <= {r_mag[bsw_pkg::MAG_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    // floor modulo: negative dividends fold back from the divisor
    assign o_result = (r_neg && (r_rem != '0)) ? (r_div - r_rem) : r_rem;
    assign o_busy   = r_busy;

endmodule

@@ hw/rtl/bsw_dp.sv @@
module bsw_dp #(
    parameter int MAX_COLS     = bsw_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS     = bsw_pkg::DEF_MAX_ROWS,
    parameter int CHANNEL_BITS = bsw_pkg::DEF_CHANNEL_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  bsw_pkg::t_cmd                         i_cmd,
    output bsw_pkg::t_status                      o_status,
    input  logic                                  i_cfg_valid,
    input  logic        [bsw_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic        [bsw_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                                  i_command,
    input  logic        [bsw_pkg::PIX_W-1:0]      i_pixel_col,
    input  logic        [bsw_pkg::PIX_W-1:0]      i_pixel_row,
    input  logic        [bsw_pkg::IN_CH_W-1:0]    i_red_in,
    input  logic        [bsw_pkg::IN_CH_W-1:0]    i_green_in,
    input  logic        [bsw_pkg::IN_CH_W-1:0]    i_blue_in,
    input  logic signed [bsw_pkg::COORD_W-1:0]    i_u_coord,
    input  logic signed [bsw_pkg::COORD_W-1:0]    i_v_coord,
    output logic        [bsw_pkg::OUT_CH_W-1:0]   o_red_out,
    output logic        [bsw_pkg::OUT_CH_W-1:0]   o_green_out,
    output logic        [bsw_pkg::OUT_CH_W-1:0]   o_blue_out
);

    localparam int CW    = $clog2(MAX_COLS);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CB    = CHANNEL_BITS;
    localparam int ACC_W = CB + 2 * bsw_pkg::FRAC_BITS;
    localparam int MUL_W = CB + bsw_pkg::BLEND_W;

    logic [bsw_pkg::CFG_W-1:0] r_cfg_w;
    logic [bsw_pkg::CFG_W-1:0] r_cfg_h;
    logic [bsw_pkg::CFG_W-1:0] w_eff;
    logic [bsw_pkg::CFG_W-1:0] h_eff;

    logic signed [bsw_pkg::PROD_W-1:0] r_xprod;
    logic signed [bsw_pkg::PROD_W-1:0] r_yprod;
    logic                              r_zero;

    logic signed [bsw_pkg::PROD_W-1:0] x_full;
    logic signed [bsw_pkg::PROD_W-1:0] y_full;
    logic signed [bsw_pkg::FLR_W-1:0]  x0;
    logic signed [bsw_pkg::FLR_W-1:0]  y0;
    logic signed [bsw_pkg::FLR_W:0]    y0e;
    logic signed [bsw_pkg::FLR_W:0]    y1e;
    logic signed [bsw_pkg::FLR_W:0]    hmax;
    logic signed [bsw_pkg::FLR_W:0]    py0_c;
    logic signed [bsw_pkg::FLR_W:0]    py1_c;

    logic [bsw_pkg::FRAC_BITS-1:0] r_dx;
    logic [bsw_pkg::FRAC_BITS-1:0] r_dy;
    logic [RW-1:0]                 r_py0;
    logic [RW-1:0]                 r_py1;
    logic [CW-1:0]                 r_px0;
    logic [CW-1:0]                 r_px1;

    logic                      mod_busy;
    logic [bsw_pkg::CFG_W-1:0] mod_px;
    logic [bsw_pkg::CFG_W:0]   px_inc;

    logic [CW-1:0]   sel_col;
    logic [RW-1:0]   sel_row;
    logic [AW-1:0]   rd_addr;
    logic [AW-1:0]   wr_addr;
    logic [AW-1:0]   mem_addr;
    logic            we;
    logic [3*CB-1:0] wdata;

    logic [3*CB-1:0] r_mem [DEPTH];
    logic [3*CB-1:0] r_rdata;

    logic [bsw_pkg::WT_W-1:0]    wx;
    logic [bsw_pkg::WT_W-1:0]    wy;
    logic [bsw_pkg::BLEND_W-1:0] r_wt;
    logic                        r_rd_vld;
    logic                        r_prod_vld;

    logic [ACC_W-1:0]            r_prod [3];
    logic [ACC_W-1:0]            r_acc  [3];
    logic [bsw_pkg::OUT_CH_W-1:0] r_out [3];

    assign w_eff = (32'(r_cfg_w) > MAX_COLS) ? bsw_pkg::CFG_W'(MAX_COLS) : r_cfg_w;
    assign h_eff = (32'(r_cfg_h) > MAX_ROWS) ? bsw_pkg::CFG_W'(MAX_ROWS) : r_cfg_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= bsw_pkg::RST_IMAGE_WIDTH;
            r_cfg_h <= bsw_pkg::RST_IMAGE_HEIGHT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                bsw_pkg::REG_IMAGE_WIDTH:  r_cfg_w <= i_cfg_data;
                bsw_pkg::REG_IMAGE_HEIGHT: r_cfg_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // coordinate scaling
    always_ff @(posedge i_clk) begin
        if (i_cmd.sample) begin
            r_xprod <= i_u_coord * $signed({1'b0, w_eff});
            r_yprod <= i_v_coord * $signed({1'b0, h_eff});
            r_zero  <= (w_eff == '0) || (h_eff == '0);
        end
    end

    assign x_full = r_xprod - bsw_pkg::HALF_FX;
    assign y_full = r_yprod - bsw_pkg::HALF_FX;
    assign x0     = x_full[bsw_pkg::PROD_W-1:bsw_pkg::FRAC_BITS];
    assign y0     = y_full[bsw_pkg::PROD_W-1:bsw_pkg::FRAC_BITS];

    // row clamp
    assign y0e   = {y0[bsw_pkg::FLR_W-1], y0};
    assign y1e   = y0e + (bsw_pkg::FLR_W+1)'(1);
    assign hmax  = $signed({{(bsw_pkg::FLR_W+1-bsw_pkg::CFG_W){1'b0}}, h_eff})
                   - (bsw_pkg::FLR_W+1)'(1);
    assign py0_c = (y0e < 0) ? '0 : ((y0e > hmax) ? hmax : y0e);
    assign py1_c = (y1e < 0) ? '0 : ((y1e > hmax) ? hmax : y1e);

    always_ff @(posedge i_clk) begin
        if (i_cmd.split) begin
            r_dx  <= x_full[bsw_pkg::FRAC_BITS-1:0];
            r_dy  <= y_full[bsw_pkg::FRAC_BITS-1:0];
            r_py0 <= RW'(unsigned'(py0_c));
            r_py1 <= RW'(unsigned'(py1_c));
        end
    end

    bsw_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.split),
        .i_dividend (x0),
        .i_divisor  (w_eff),
        .o_busy     (mod_busy),
        .o_result   (mod_px)
    );

    assign px_inc = {1'b0, mod_px} + (bsw_pkg::CFG_W+1)'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.wrap) begin
            r_px0 <= CW'(mod_px);
            r_px1 <= (px_inc == {1'b0, w_eff}) ? '0 : CW'(px_inc[bsw_pkg::CFG_W-1:0]);
        end
    end

    // single-port image store
    assign sel_col  = i_cmd.nbr[0] ? r_px1 : r_px0;
    assign sel_row  = i_cmd.nbr[1] ? r_py1 : r_py0;
    assign rd_addr  = AW'(sel_row) * AW'(MAX_COLS) + AW'(sel_col);
    assign wr_addr  = AW'(i_pixel_row) * AW'(MAX_COLS) + AW'(i_pixel_col);
    assign mem_addr = i_cmd.fetch ? rd_addr : wr_addr;
    assign we       = i_cmd.accept && (i_command == bsw_pkg::CMD_WRITE)
                      && (32'(i_pixel_col) < MAX_COLS) && (32'(i_pixel_row) < MAX_ROWS);
    assign wdata    = {CB'(i_blue_in), CB'(i_green_in), CB'(i_red_in)};

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[mem_addr] <= wdata;
        end
        r_rdata <= r_mem[mem_addr];
    end

    // corner weight, fetched alongside its pixel
    assign wx = i_cmd.nbr[0] ? {1'b0, r_dx} : (bsw_pkg::ONE_FX - {1'b0, r_dx});
    assign wy = i_cmd.nbr[1] ? {1'b0, r_dy} : (bsw_pkg::ONE_FX - {1'b0, r_dy});

    always_ff @(posedge i_clk) begin
        if (i_cmd.fetch) begin
            r_wt <= wx * wy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld   <= 1'b0;
            r_prod_vld <= 1'b0;
        end else begin
            r_rd_vld   <= i_cmd.fetch;
            r_prod_vld <= r_rd_vld;
        end
    end

    for (genvar ch = 0; ch < 3; ch++) begin : g_lane
        logic [MUL_W-1:0] mul;

        assign mul = r_rdata[ch*CB +: CB] * r_wt;

        always_ff @(posedge i_clk) begin
            r_prod[ch] <= mul[ACC_W-1:0];
            if (i_cmd.wrap) begin
                r_acc[ch] <= '0;
            end else if (r_prod_vld) begin
                r_acc[ch] <= r_acc[ch] + r_prod[ch];
            end
            if (i_cmd.out_load) begin
                r_out[ch] <= r_zero ? '0
                             : bsw_pkg::OUT_CH_W'(r_acc[ch][ACC_W-1:2*bsw_pkg::FRAC_BITS]);
            end
        end
    end

    assign o_red_out       = r_out[0];
    assign o_green_out     = r_out[1];
    assign o_blue_out      = r_out[2];
    assign o_status.zero     = r_zero;
    assign o_status.mod_busy = mod_busy;

endmodule

@@ hw/rtl/bsw_ctrl.sv @@
module bsw_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_command,
    input  logic             i_ready,
    input  bsw_pkg::t_status i_status,
    output logic             o_ready,
    output logic             o_valid,
    output bsw_pkg::t_cmd    o_cmd
);

    localparam logic [1:0] NBR_LAST   = 2'd3;
    localparam logic [1:0] DRAIN_LAST = 2'd1;

    bsw_pkg::t_state r_state;
    bsw_pkg::t_state n_state;
    logic [1:0]      r_cnt;
    logic [1:0]      n_cnt;
    logic            r_out_vld;
    logic            out_free;

    assign out_free = !r_out_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= bsw_pkg::S_IDLE;
            r_cnt     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (o_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            bsw_pkg::S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_command == bsw_pkg::CMD_SAMPLE) begin
                        o_cmd.sample = 1'b1;
                        n_state      = bsw_pkg::S_PROD;
                    end
                end
            end
            bsw_pkg::S_PROD: begin
                n_state = bsw_pkg::S_SPLIT;
            end
            bsw_pkg::S_SPLIT: begin
                o_cmd.split = 1'b1;
                n_state     = i_status.zero ? bsw_pkg::S_OUT : bsw_pkg::S_MOD;
            end
            bsw_pkg::S_MOD: begin
                if (!i_status.mod_busy) begin
                    n_state = bsw_pkg::S_WRAP;
                end
            end
            bsw_pkg::S_WRAP: begin
                o_cmd.wrap = 1'b1;
                n_cnt      = '0;
                n_state    = bsw_pkg::S_FETCH;
            end
            bsw_pkg::S_FETCH: begin
                o_cmd.fetch = 1'b1;
                o_cmd.nbr   = r_cnt;
                n_cnt       = r_cnt + 2'd1;
                if (r_cnt == NBR_LAST) begin
                    n_cnt   = '0;
                    n_state = bsw_pkg::S_DRAIN;
                end
            end
            bsw_pkg::S_DRAIN: begin
                n_cnt = r_cnt + 2'd1;
                if (r_cnt == DRAIN_LAST) begin
                    n_state = bsw_pkg::S_OUT;
                end
            end
            bsw_pkg::S_OUT: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = bsw_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bsw_pkg::S_IDLE;
            end
        endcase
    end

    assign o_ready = (r_state == bsw_pkg::S_IDLE);
    assign o_valid = r_out_vld;

endmodule

@@ hw/rtl/bsw_checker.sv @@
`include "bilinear_sampler_wrap_clamp_defines.svh"

module bsw_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_valid,
    input logic                            o_ready,
    input logic                            i_command,
    input logic                            o_valid,
    input logic                            i_ready,
    input logic [bsw_pkg::OUT_CH_W-1:0]    o_red_out,
    input logic [bsw_pkg::OUT_CH_W-1:0]    o_green_out,
    input logic [bsw_pkg::OUT_CH_W-1:0]    o_blue_out
);

    logic in_beat;

    assign in_beat = i_valid && o_ready;

    // stalled result beat holds
    `BSW_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready,
        o_valid && $stable(o_red_out) && $stable(o_green_out) && $stable(o_blue_out),
        "result beat changed while stalled")

    // a sample beat makes the block busy
    `BSW_ASSERT_NXT(a_sample_busy, i_clk, i_rst_n, in_beat && i_command,
        !o_ready, "still ready after sample beat")

    // a write beat finishes in its own cycle
    `BSW_ASSERT_NXT(a_write_ready, i_clk, i_rst_n, in_beat && !i_command,
        o_ready, "not ready after write beat")

    // no result appears right behind a sample beat
    `BSW_ASSERT_IMP(a_no_early_result, i_clk, i_rst_n, $past(in_beat && i_command),
        !$rose(o_valid), "result raised too early")

endmodule

bind bilinear_sampler_wrap_clamp bsw_checker u_bsw_checker (.*);

@@ sim/bsw_sample_checker.sv @@
module bsw_sample_checker
    import bsw_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    input  logic                        i_cfg_ready,
    input  logic        [CFG_IDX_W-1:0] i_cfg_index,
    input  logic        [CFG_W-1:0]     i_cfg_data,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic                        i_command,
    input  logic        [PIX_W-1:0]     i_pixel_col,
    input  logic        [PIX_W-1:0]     i_pixel_row,
    input  logic        [IN_CH_W-1:0]   i_red_in,
    input  logic        [IN_CH_W-1:0]   i_green_in,
    input  logic        [IN_CH_W-1:0]   i_blue_in,
    input  logic signed [COORD_W-1:0]   i_u_coord,
    input  logic signed [COORD_W-1:0]   i_v_coord,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic        [OUT_CH_W-1:0]  i_red_out,
    input  logic        [OUT_CH_W-1:0]  i_green_out,
    input  logic        [OUT_CH_W-1:0]  i_blue_out,
    output int                          o_fail_count,
    output int                          o_pending,
    output int                          o_compared
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [OUT_CH_W-1:0] red;
        logic [OUT_CH_W-1:0] green;
        logic [OUT_CH_W-1:0] blue;
    } t_rgb;

    t_rgb             image_mem [DEF_MAX_COLS * DEF_MAX_ROWS];
    t_rgb             expected_rgb [$];
    logic [CFG_W-1:0] cur_width  = RST_IMAGE_WIDTH;
    logic [CFG_W-1:0] cur_height = RST_IMAGE_HEIGHT;
    int               fail_count = 0;
    int               compared   = 0;

    task automatic report_error(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        fail_count++;
    endtask

    function automatic longint mix16(input longint a, input longint b, input longint w);
        return a * (longint'(ONE_FX) - w) + b * w;
    endfunction

    // Exact 16.16 blend of the four neighbours, truncated once at the end.
    function automatic t_rgb bilinear_rgb(input logic signed [COORD_W-1:0] u,
                                          input logic signed [COORD_W-1:0] v);
        longint cols, rows, xs, ys, x0, y0, dx, dy, col0, col1, row0, row1;
        t_rgb   p00, p10, p01, p11, res;
        cols = (cur_width > DEF_MAX_COLS) ? DEF_MAX_COLS : cur_width;
        rows = (cur_height > DEF_MAX_ROWS) ? DEF_MAX_ROWS : cur_height;
        if (cols == 0 || rows == 0) begin
            return '0;
        end
        xs = longint'(u) * cols - longint'(HALF_FX);
        ys = longint'(v) * rows - longint'(HALF_FX);
        x0 = xs >>> FRAC_BITS;
        y0 = ys >>> FRAC_BITS;
        dx = longint'(xs[FRAC_BITS-1:0]);
        dy = longint'(ys[FRAC_BITS-1:0]);
        col0 = x0 % cols;
        if (col0 < 0) begin
            col0 += cols;
        end
        col1 = (col0 + 1) % cols;
        row0 = (y0 < 0) ? 0 : ((y0 > rows - 1) ? rows - 1 : y0);
        row1 = (y0 + 1 < 0) ? 0 : ((y0 + 1 > rows - 1) ? rows - 1 : y0 + 1);
        p00 = image_mem[row0 * DEF_MAX_COLS + col0];
        p10 = image_mem[row0 * DEF_MAX_COLS + col1];
        p01 = image_mem[row1 * DEF_MAX_COLS + col0];
        p11 = image_mem[row1 * DEF_MAX_COLS + col1];
        res.red   = OUT_CH_W'(mix16(mix16(p00.red, p10.red, dx),
                                    mix16(p01.red, p11.red, dx), dy) >> 32);
        res.green = OUT_CH_W'(mix16(mix16(p00.green, p10.green, dx),
                                    mix16(p01.green, p11.green, dx), dy) >> 32);
        res.blue  = OUT_CH_W'(mix16(mix16(p00.blue, p10.blue, dx),
                                    mix16(p01.blue, p11.blue, dx), dy) >> 32);
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_rgb want;
        if (!i_rst_n) begin
            cur_width  = RST_IMAGE_WIDTH;
            cur_height = RST_IMAGE_HEIGHT;
            expected_rgb.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_IMAGE_WIDTH:  cur_width  = i_cfg_data;
                    REG_IMAGE_HEIGHT: cur_height = i_cfg_data;
                    default: ;
                endcase
            end
            // results go first: a beat accepted on this edge cannot be answered yet
            if (i_out_valid && i_out_ready) begin
                compared++;
                if (expected_rgb.size() == 0) begin
                    report_error($sformatf("result %04h %04h %04h with nothing expected",
                                           i_red_out, i_green_out, i_blue_out));
                end else begin
                    want = expected_rgb.pop_front();
                    if (i_red_out !== want.red)
                        report_error($sformatf("red expected %04h got %04h",
                                               want.red, i_red_out));
                    if (i_green_out !== want.green)
                        report_error($sformatf("green expected %04h got %04h",
                                               want.green, i_green_out));
                    if (i_blue_out !== want.blue)
                        report_error($sformatf("blue expected %04h got %04h",
                                               want.blue, i_blue_out));
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_command == CMD_WRITE) begin
                    image_mem[int'(i_pixel_row) * DEF_MAX_COLS + int'(i_pixel_col)] =
                        {i_red_in, i_green_in, i_blue_in};
                end else begin
                    expected_rgb.push_back(bilinear_rgb(i_u_coord, i_v_coord));
                end
            end
        end
        o_pending    <= expected_rgb.size();
        o_fail_count <= fail_count;
        o_compared   <= compared;
    end

endmodule

@@ sim/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import bsw_pkg::*;

    localparam int NUM_PHASES      = 16;
    localparam int ITEMS_PER_PHASE = 24;
    localparam int SETTLE_CYCLES   = 40;
    localparam int LIMIT_NS        = 8_000_000;

    localparam logic [CFG_IDX_W-1:0]    UNUSED_REG_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0]    UNUSED_REG_B = 2'd3;
    localparam logic signed [COORD_W-1:0] COORD_MAX = 20'sh7FFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 20'sh80000;

    typedef struct {
        logic                      command;
        logic [PIX_W-1:0]          col;
        logic [PIX_W-1:0]          row;
        logic [IN_CH_W-1:0]        red;
        logic [IN_CH_W-1:0]        green;
        logic [IN_CH_W-1:0]        blue;
        logic signed [COORD_W-1:0] u;
        logic signed [COORD_W-1:0] v;
    } t_beat;

    logic                        i_clk       = 1'b0;
    logic                        i_rst_n     = 1'b0;
    logic                        i_cfg_valid = 1'b0;
    logic                        o_cfg_ready;
    logic        [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic        [CFG_W-1:0]     i_cfg_data  = '0;
    logic                        i_valid     = 1'b0;
    logic                        o_ready;
    logic                        i_command   = CMD_WRITE;
    logic        [PIX_W-1:0]     i_pixel_col = '0;
    logic        [PIX_W-1:0]     i_pixel_row = '0;
    logic        [IN_CH_W-1:0]   i_red_in    = '0;
    logic        [IN_CH_W-1:0]   i_green_in  = '0;
    logic        [IN_CH_W-1:0]   i_blue_in   = '0;
    logic signed [COORD_W-1:0]   i_u_coord   = '0;
    logic signed [COORD_W-1:0]   i_v_coord   = '0;
    logic                        o_valid;
    logic                        i_ready     = 1'b0;
    logic        [OUT_CH_W-1:0]  o_red_out;
    logic        [OUT_CH_W-1:0]  o_green_out;
    logic        [OUT_CH_W-1:0]  o_blue_out;

    int fail_count;
    int pending;
    int compared;

    int send_idle_pct = 12;
    int recv_idle_pct = 88;
    int eff_cols      = 0;
    int eff_rows      = 0;
    int pixel_writes  = 0;
    int samples_sent  = 0;
    int cfg_writes    = 0;
    int size_settings = 0;
    bit written [DEF_MAX_ROWS][DEF_MAX_COLS];

    bilinear_sampler_wrap_clamp uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_command   (i_command),
        .i_pixel_col (i_pixel_col),
        .i_pixel_row (i_pixel_row),
        .i_red_in    (i_red_in),
        .i_green_in  (i_green_in),
        .i_blue_in   (i_blue_in),
        .i_u_coord   (i_u_coord),
        .i_v_coord   (i_v_coord),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_red_out   (o_red_out),
        .o_green_out (o_green_out),
        .o_blue_out  (o_blue_out)
    );

    bsw_sample_checker sampler_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_command    (i_command),
        .i_pixel_col  (i_pixel_col),
        .i_pixel_row  (i_pixel_row),
        .i_red_in     (i_red_in),
        .i_green_in   (i_green_in),
        .i_blue_in    (i_blue_in),
        .i_u_coord    (i_u_coord),
        .i_v_coord    (i_v_coord),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_red_out    (o_red_out),
        .i_green_out  (o_green_out),
        .i_blue_out   (o_blue_out),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_compared   (compared)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    function automatic logic [IN_CH_W-1:0] pick_channel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return IN_CH_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [COORD_W-1:0] random_coord();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return COORD_W'($urandom);
            5, 6, 7:       return COORD_W'($urandom_range(0, 4 * 65536) - 2 * 65536);
            // near multiples of a quarter, one lsb either side
            8:       return COORD_W'(($urandom_range(0, 8) - 4) * 16384
                                     + $urandom_range(0, 2) - 1);
            default: return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
        endcase
    endfunction

    // valid stays high between back-to-back beats; a gap or a drain lowers it
    task automatic send_beat(input t_beat b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_command   <= b.command;
        i_pixel_col <= b.col;
        i_pixel_row <= b.row;
        i_red_in    <= b.red;
        i_green_in  <= b.green;
        i_blue_in   <= b.blue;
        i_u_coord   <= b.u;
        i_v_coord   <= b.v;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic write_pixel(input logic [PIX_W-1:0] col, input logic [PIX_W-1:0] row,
                               input logic [IN_CH_W-1:0] red,
                               input logic [IN_CH_W-1:0] green,
                               input logic [IN_CH_W-1:0] blue);
        t_beat b;
        b.command = CMD_WRITE;
        b.col     = col;
        b.row     = row;
        b.red     = red;
        b.green   = green;
        b.blue    = blue;
        b.u       = COORD_W'($urandom);
        b.v       = COORD_W'($urandom);
        send_beat(b);
        written[row][col] = 1'b1;
        pixel_writes++;
    endtask

    task automatic sample_at(input logic signed [COORD_W-1:0] u,
                             input logic signed [COORD_W-1:0] v);
        t_beat b;
        b.command = CMD_SAMPLE;
        b.col     = PIX_W'($urandom);
        b.row     = PIX_W'($urandom);
        b.red     = pick_channel();
        b.green   = pick_channel();
        b.blue    = pick_channel();
        b.u       = u;
        b.v       = v;
        send_beat(b);
        samples_sent++;
    endtask

    task automatic random_write();
        logic [PIX_W-1:0] col;
        logic [PIX_W-1:0] row;
        if (eff_cols != 0 && eff_rows != 0 && $urandom_range(0, 9) < 7) begin
            col = PIX_W'($urandom_range(0, eff_cols - 1));
            row = PIX_W'($urandom_range(0, eff_rows - 1));
        end else begin
            col = PIX_W'($urandom);
            row = PIX_W'($urandom);
        end
        write_pixel(col, row, pick_channel(), pick_channel(), pick_channel());
    endtask

    // every pixel a sample can reach must hold a written value
    task automatic fill_region();
        for (int r = 0; r < eff_rows; r++) begin
            for (int c = 0; c < eff_cols; c++) begin
                if (!written[r][c])
                    write_pixel(PIX_W'(c), PIX_W'(r), pick_channel(), pick_channel(),
                                pick_channel());
            end
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // writes leave no result behind, so give the pipeline time to go quiet
    task automatic quiesce();
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        cfg_writes++;
    endtask

    task automatic set_size(input int w, input int h);
        quiesce();
        cfg_write(REG_IMAGE_WIDTH, CFG_W'(w));
        cfg_write(REG_IMAGE_HEIGHT, CFG_W'(h));
        eff_cols = (w > DEF_MAX_COLS) ? DEF_MAX_COLS : w;
        eff_rows = (h > DEF_MAX_ROWS) ? DEF_MAX_ROWS : h;
        size_settings++;
    endtask

    initial begin
        #LIMIT_NS;
        $display("FAIL");
        $finish;
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_size(3, 2);
        write_pixel(8'd0, 8'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        write_pixel(8'd1, 8'd0, 16'h0000, 16'h0000, 16'h0000);
        write_pixel(8'd2, 8'd0, 16'hFFFF, 16'h0000, 16'h8000);
        write_pixel(8'd0, 8'd1, 16'h0000, 16'hFFFF, 16'h0001);
        write_pixel(8'd1, 8'd1, 16'h7FFF, 16'h8000, 16'hFFFE);
        write_pixel(8'd2, 8'd1, 16'h00FF, 16'hFF00, 16'h5A5A);
        sample_at(COORD_W'(0), COORD_W'(0));
        sample_at(COORD_MAX, COORD_MAX);
        sample_at(COORD_MIN, COORD_MIN);
        sample_at(COORD_MIN, COORD_MAX);
        sample_at(COORD_W'(32768), COORD_W'(32768));
        sample_at(COORD_W'(-1), COORD_W'(65535));
        sample_at(COORD_W'(65536), COORD_W'(-65536));
        sample_at(COORD_W'(21845), COORD_W'(49152));
        sample_at(COORD_W'(-200000), COORD_W'(100));
        // writes to unmapped indexes must leave the size alone
        quiesce();
        cfg_write(UNUSED_REG_A, '1);
        cfg_write(UNUSED_REG_B, '0);
        sample_at(COORD_W'(32768), COORD_W'(32768));
        set_size(0, 2);
        sample_at(COORD_W'(40000), COORD_W'(12345));
        set_size(3, 0);
        sample_at(COORD_W'(-7), COORD_W'(70000));

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph * 3 / NUM_PHASES)
                0: begin
                    send_idle_pct = 12;
                    recv_idle_pct = 88;
                end
                1: begin
                    send_idle_pct = 88;
                    recv_idle_pct = 12;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            case (ph)
                0: set_size(256, 1);
                1: set_size(1, 256);
                2: set_size(511, 1);
                3: set_size(2, 511);
                default: set_size($urandom_range(0, 7) == 0 ? 0 : $urandom_range(1, 12),
                                  $urandom_range(0, 7) == 0 ? 0 : $urandom_range(1, 12));
            endcase
            fill_region();
            repeat (ITEMS_PER_PHASE) begin
                if ($urandom_range(0, 59) == 0)
                    drain();
                if ($urandom_range(0, 99) < 35)
                    random_write();
                else
                    sample_at(random_coord(), random_coord());
            end
        end

        quiesce();
        $display("covered %0d pixel writes and %0d samples over %0d image sizes",
                 pixel_writes, samples_sent, size_settings);
        $display("%0d register writes, %0d blended colors compared, %0d mismatches",
                 cfg_writes, compared, fail_count);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
